### hdl/mmrs_pkg.sv
// Shared types and constants for the memory map region scanner.
package mmrs_pkg;

  localparam int ADDR_W  = 52;
  localparam int PAGES_W = 40;
  localparam int TOTAL_W = 64;
  localparam int SHIFT_W = 6;
  localparam int PAGE_SHIFT = 12;

  localparam logic [7:0] TYPE_LOADER_CODE   = 8'd1;
  localparam logic [7:0] TYPE_LOADER_DATA   = 8'd2;
  localparam logic [7:0] TYPE_BOOT_CODE     = 8'd3;
  localparam logic [7:0] TYPE_BOOT_DATA     = 8'd4;
  localparam logic [7:0] TYPE_CONVENTIONAL  = 8'd7;

  localparam logic [ADDR_W-1:0] LOW_LIMIT = 52'h0_0000_0010_0000;

  localparam logic [ADDR_W-1:0]  KERNEL_SIZE_RESET = 52'd16777216;
  localparam logic [SHIFT_W-1:0] ALIGN_SHIFT_RESET = 6'd12;

  // Register indexes (byte address = 8 * index).
  localparam logic REG_KERNEL_SIZE = 1'b0;
  localparam logic REG_ALIGN_SHIFT = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]  kernel_size;
    logic [SHIFT_W-1:0] align_shift;
  } cfg_t;

  // Classified descriptor handed from front to back.
  typedef struct packed {
    logic              usable;
    logic              conv;
    logic              fit;
    logic              last;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] bytes;
    logic [ADDR_W-1:0] fit_base;
  } desc_t;

endpackage

### hdl/mmrs_front.sv
// Front end: accepts descriptors, classifies them and checks the aligned fit.
module mmrs_front (
  input  logic                      clk,
  input  logic                      rst,
  input  mmrs_pkg::cfg_t            cfg,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                mem_type,
  input  logic [51:0]               region_base,
  input  logic [39:0]               region_pages,
  input  logic                      last_entry,
  output logic                      q_push,
  output mmrs_pkg::desc_t           q_data,
  input  logic                      q_full
);
  import mmrs_pkg::*;

  // stage A: classify, region end and rounded-up base
  logic              a_valid;
  logic              a_usable;
  logic              a_conv;
  logic              a_cand;
  logic              a_last;
  logic [ADDR_W-1:0] a_start;
  logic [ADDR_W-1:0] a_bytes;
  logic [ADDR_W:0]   a_end;
  logic [63:0]       a_aligned;

  // stage B: finished descriptor
  logic  b_valid;
  desc_t b;

  logic        a_ready;
  logic        b_ready;
  logic        accept;
  logic [63:0] amask;
  logic [63:0] rounded;
  logic [ADDR_W-1:0] bytes_in;
  logic        fit_ok;
  logic [ADDR_W:0] room;

  assign b_ready = !b_valid || !q_full;
  assign a_ready = !a_valid || b_ready;
  assign full    = !a_ready;
  assign accept  = push && a_ready;

  assign bytes_in = {region_pages, {PAGE_SHIFT{1'b0}}};
  assign amask    = (64'd1 << cfg.align_shift) - 64'd1;
  assign rounded  = ({12'd0, region_base} + amask) & ~amask;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_usable  <= mem_type inside {TYPE_LOADER_CODE, TYPE_LOADER_DATA, TYPE_BOOT_CODE,
                                    TYPE_BOOT_DATA, TYPE_CONVENTIONAL};
      a_conv    <= mem_type == TYPE_CONVENTIONAL;
      a_cand    <= (mem_type == TYPE_CONVENTIONAL) && (region_base >= LOW_LIMIT) &&
                   (cfg.kernel_size != '0);
      a_last    <= last_entry;
      a_start   <= region_base;
      a_bytes   <= bytes_in;
      a_end     <= {1'b0, region_base} + {1'b0, bytes_in};
      a_aligned <= rounded;
    end
  end

  assign room   = a_end - a_aligned[ADDR_W:0];
  assign fit_ok = a_cand && (a_aligned[63:ADDR_W] == '0) &&
                  ({1'b0, a_aligned[ADDR_W-1:0]} < a_end) &&
                  (room >= {1'b0, cfg.kernel_size});

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b.usable   <= a_usable;
      b.conv     <= a_conv;
      b.fit      <= fit_ok;
      b.last     <= a_last;
      b.start    <= a_start;
      b.bytes    <= a_bytes;
      b.fit_base <= a_aligned[ADDR_W-1:0];
    end
  end

  assign q_push = b_valid && !q_full;
  assign q_data = b;

endmodule

### hdl/mmrs_queue.sv
// Small descriptor queue between front and back.
module mmrs_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mmrs_pkg::desc_t wdata,
  output logic            full,
  input  logic            pop,
  output mmrs_pkg::desc_t rdata,
  output logic            empty
);
  import mmrs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/mmrs_back.sv
// Back end: running totals, largest region, first fit and the result register.
module mmrs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  mmrs_pkg::desc_t q_data,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output logic            largest_found,
  output logic [51:0]     largest_start,
  output logic [51:0]     largest_bytes,
  output logic [63:0]     usable_total,
  output logic            kernel_found,
  output logic [51:0]     kernel_base
);
  import mmrs_pkg::*;

  logic [ADDR_W-1:0]  best_base;
  logic [ADDR_W-1:0]  best_bytes;
  logic [TOTAL_W-1:0] total_bytes;
  logic               fit_found;
  logic [ADDR_W-1:0]  fit_base;

  logic [ADDR_W-1:0]  best_base_next;
  logic [ADDR_W-1:0]  best_bytes_next;
  logic [TOTAL_W-1:0] total_bytes_next;
  logic               fit_found_next;
  logic [ADDR_W-1:0]  fit_base_next;

  logic               res_valid;
  logic               out_ready;
  logic               step;
  logic [TOTAL_W:0]   sum;

  assign out_ready = !res_valid || pop;
  // a last descriptor waits until the result slot frees up
  assign step  = !q_empty && (!q_data.last || out_ready);
  assign q_pop = step;
  assign empty = !res_valid;

  assign sum = {1'b0, total_bytes} + {13'd0, q_data.bytes};

  always_comb begin
    best_base_next   = best_base;
    best_bytes_next  = best_bytes;
    total_bytes_next = total_bytes;
    fit_found_next   = fit_found;
    fit_base_next    = fit_base;
    if (q_data.usable) begin
      total_bytes_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    end
    if (q_data.conv && (q_data.bytes > best_bytes)) begin
      best_bytes_next = q_data.bytes;
      best_base_next  = q_data.start;
    end
    if (!fit_found && q_data.fit) begin
      fit_found_next = 1'b1;
      fit_base_next  = q_data.fit_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_base   <= '0;
      best_bytes  <= '0;
      total_bytes <= '0;
      fit_found   <= 1'b0;
      fit_base    <= '0;
    end else if (step) begin
      if (q_data.last) begin
        best_base   <= '0;
        best_bytes  <= '0;
        total_bytes <= '0;
        fit_found   <= 1'b0;
        fit_base    <= '0;
      end else begin
        best_base   <= best_base_next;
        best_bytes  <= best_bytes_next;
        total_bytes <= total_bytes_next;
        fit_found   <= fit_found_next;
        fit_base    <= fit_base_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= step && q_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (step && q_data.last) begin
      largest_found <= best_bytes_next != '0;
      largest_start <= best_base_next;
      largest_bytes <= best_bytes_next;
      usable_total  <= total_bytes_next;
      kernel_found  <= fit_found_next;
      kernel_base   <= fit_base_next;
    end
  end

`ifndef SYNTHESIS
  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    (step && q_data.last) |=> res_valid)
    else $error("result missing after last descriptor");
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (step && q_data.last) |=> (total_bytes == '0 && best_bytes == '0 && !fit_found))
    else $error("state not cleared after result");
  a_found_matches: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (largest_found == (largest_bytes != '0)))
    else $error("largest_found disagrees with largest_bytes");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !pop) |-> !(step && q_data.last))
    else $error("pending result overwritten");
`endif

endmodule

### hdl/memory_map_region_scanner.sv
// Top level: configuration registers, front end, descriptor queue, back end.
//
//  channel      | handshake              | payload
//  -------------+------------------------+-------------------------------------------
//  descriptor   | push / full            | mem_type, region_base, region_pages, last_entry
//  result       | pop / empty            | largest_*, usable_total, kernel_found/base
//  config (APB) | psel/penable/pwrite    | paddr, pwdata, prdata (64-bit, 8-byte stride)
//
// One descriptor per cycle sustained while full stays low. An accepted descriptor
// passes front stages A and B and the queue to the back end's input, where it is
// folded in; folding a last descriptor registers its result onto the result ports.
// Reset (rst, synchronous) clears pipeline, queue and running state and loads
// the register defaults. A stalled result consumer only holds back a last
// descriptor; the queue absorbs others until it fills.
module memory_map_region_scanner #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  mem_type,
  input  logic [51:0] region_base,
  input  logic [39:0] region_pages,
  input  logic        last_entry,
  output logic        empty,
  input  logic        pop,
  output logic        largest_found,
  output logic [51:0] largest_start,
  output logic [51:0] largest_bytes,
  output logic [63:0] usable_total,
  output logic        kernel_found,
  output logic [51:0] kernel_base
);
  import mmrs_pkg::*;

  cfg_t  cfg;
  logic  cfg_wr;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  desc_t q_wdata;
  desc_t q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel_size <= KERNEL_SIZE_RESET;
      cfg.align_shift <= ALIGN_SHIFT_RESET;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_KERNEL_SIZE: cfg.kernel_size <= pwdata[ADDR_W-1:0];
        REG_ALIGN_SHIFT: cfg.align_shift <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_KERNEL_SIZE: prdata = {12'd0, cfg.kernel_size};
      REG_ALIGN_SHIFT: prdata = {58'd0, cfg.align_shift};
      default:         prdata = '0;
    endcase
  end

  mmrs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .mem_type     (mem_type),
    .region_base  (region_base),
    .region_pages (region_pages),
    .last_entry   (last_entry),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  mmrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  mmrs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .largest_found (largest_found),
    .largest_start (largest_start),
    .largest_bytes (largest_bytes),
    .usable_total  (usable_total),
    .kernel_found  (kernel_found),
    .kernel_base   (kernel_base)
  );

endmodule

### tb/region_scan_checker.sv
// Checker: follows register writes and descriptors, predicts each map summary, compares results.
module region_scan_checker
  import mmrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  input  logic               pready,
  input  logic               push,
  input  logic               full,
  input  logic [7:0]         mem_type,
  input  logic [ADDR_W-1:0]  region_base,
  input  logic [PAGES_W-1:0] region_pages,
  input  logic               last_entry,
  input  logic               empty,
  input  logic               pop,
  input  logic               largest_found,
  input  logic [ADDR_W-1:0]  largest_start,
  input  logic [ADDR_W-1:0]  largest_bytes,
  input  logic [TOTAL_W-1:0] usable_total,
  input  logic               kernel_found,
  input  logic [ADDR_W-1:0]  kernel_base,
  output int                 fail_count,
  output int                 pending,
  output int                 descriptors_seen,
  output int                 results_checked
);

  typedef struct packed {
    logic               largest_found;
    logic [ADDR_W-1:0]  largest_start;
    logic [ADDR_W-1:0]  largest_bytes;
    logic [TOTAL_W-1:0] usable_total;
    logic               kernel_found;
    logic [ADDR_W-1:0]  kernel_base;
  } map_summary_t;

  map_summary_t expected_maps[$];

  logic [ADDR_W-1:0]  cfg_kernel_size;
  logic [SHIFT_W-1:0] cfg_align_shift;

  // running state of the map being scanned
  logic [ADDR_W-1:0]  best_base;
  logic [ADDR_W-1:0]  best_bytes;
  logic [TOTAL_W-1:0] usable_sum;
  logic               fit_hit;
  logic [ADDR_W-1:0]  fit_addr;

  function automatic void clear_running();
    best_base  = '0;
    best_bytes = '0;
    usable_sum = '0;
    fit_hit    = 1'b0;
    fit_addr   = '0;
  endfunction

  function automatic int field_mismatch(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : track
    logic [ADDR_W-1:0]  bytes;
    logic [TOTAL_W:0]   sum;
    logic [63:0]        amask;
    logic [63:0]        span_end;
    logic [63:0]        aligned;
    map_summary_t       got;
    map_summary_t       want;
    if (rst) begin
      cfg_kernel_size = KERNEL_SIZE_RESET;
      cfg_align_shift = ALIGN_SHIFT_RESET;
      clear_running();
      expected_maps.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_KERNEL_SIZE, 3'b000})
          cfg_kernel_size = pwdata[ADDR_W-1:0];
        else if (paddr == {REG_ALIGN_SHIFT, 3'b000})
          cfg_align_shift = pwdata[SHIFT_W-1:0];
      end

      // results first: a result never belongs to a request taken at the same edge
      if (pop && !empty) begin
        got = {largest_found, largest_start, largest_bytes, usable_total,
               kernel_found, kernel_base};
        if (expected_maps.size() == 0) begin
          $error("result popped with no map summary pending");
          fail_count++;
        end else begin
          want = expected_maps.pop_front();
          fail_count += field_mismatch("largest_found", 64'(want.largest_found),
                                       64'(got.largest_found));
          fail_count += field_mismatch("largest_start", 64'(want.largest_start),
                                       64'(got.largest_start));
          fail_count += field_mismatch("largest_bytes", 64'(want.largest_bytes),
                                       64'(got.largest_bytes));
          fail_count += field_mismatch("usable_total", want.usable_total, got.usable_total);
          fail_count += field_mismatch("kernel_found", 64'(want.kernel_found),
                                       64'(got.kernel_found));
          fail_count += field_mismatch("kernel_base", 64'(want.kernel_base),
                                       64'(got.kernel_base));
          results_checked++;
        end
      end

      if (push && !full) begin
        descriptors_seen++;
        bytes = {region_pages, 12'h000};
        if (mem_type == TYPE_LOADER_CODE || mem_type == TYPE_LOADER_DATA ||
            mem_type == TYPE_BOOT_CODE || mem_type == TYPE_BOOT_DATA ||
            mem_type == TYPE_CONVENTIONAL) begin
          sum = {1'b0, usable_sum} + {13'd0, bytes};
          usable_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        end
        if (mem_type == TYPE_CONVENTIONAL) begin
          // ties keep the earlier region
          if (bytes > best_bytes) begin
            best_bytes = bytes;
            best_base  = region_base;
          end
          if (!fit_hit && region_base >= LOW_LIMIT && cfg_kernel_size != '0) begin
            amask    = (64'd1 << cfg_align_shift) - 64'd1;
            span_end = {12'd0, region_base} + {12'd0, bytes};
            aligned  = ({12'd0, region_base} + amask) & ~amask;
            if (aligned[63:ADDR_W] == '0 && aligned < span_end &&
                span_end - aligned >= {12'd0, cfg_kernel_size}) begin
              fit_hit  = 1'b1;
              fit_addr = aligned[ADDR_W-1:0];
            end
          end
        end
        if (last_entry) begin
          want.largest_found = (best_bytes != '0);
          want.largest_start = best_base;
          want.largest_bytes = best_bytes;
          want.usable_total  = usable_sum;
          want.kernel_found  = fit_hit;
          want.kernel_base   = fit_addr;
          expected_maps.push_back(want);
          clear_running();
        end
      end
    end
    pending = expected_maps.size();
  end

endmodule

### tb/memory_map_region_scanner_test.sv
// Testbench top: clock, reset, register writes, descriptor and result traffic, verdict.
module memory_map_region_scanner_test;
  import mmrs_pkg::*;

  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 10;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 90;
  localparam int PRESSURE_PHASE = 5;
  localparam int PRESSURE_MAPS  = 24;
  localparam int HOLD_CYCLES    = 300;
  localparam int BIG_MAP_PHASE  = 8;
  localparam int BIG_MAP_LEN    = 300;

  localparam logic [ADDR_W-1:0]  ADDR_MAX  = {ADDR_W{1'b1}};
  localparam logic [PAGES_W-1:0] PAGES_MAX = {PAGES_W{1'b1}};

  // type codes that are neither usable nor conventional
  localparam logic [7:0] TYPE_RESERVED      = 8'd0;
  localparam logic [7:0] TYPE_RUNTIME_CODE  = 8'd5;
  localparam logic [7:0] TYPE_PERSISTENT    = 8'd14;
  localparam logic [7:0] TYPE_FIRST_UNKNOWN = 8'd15;
  localparam logic [7:0] TYPE_TOP_CODE      = 8'd255;

  typedef struct packed {
    logic [7:0]         kind;
    logic [ADDR_W-1:0]  base;
    logic [PAGES_W-1:0] pages;
  } region_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;
  logic               push;
  logic               full;
  logic [7:0]         mem_type;
  logic [ADDR_W-1:0]  region_base;
  logic [PAGES_W-1:0] region_pages;
  logic               last_entry;
  logic               empty;
  logic               pop;
  logic               largest_found;
  logic [ADDR_W-1:0]  largest_start;
  logic [ADDR_W-1:0]  largest_bytes;
  logic [TOTAL_W-1:0] usable_total;
  logic               kernel_found;
  logic [ADDR_W-1:0]  kernel_base;

  int fail_count;
  int pending;
  int descriptors_seen;
  int results_checked;

  int tx_idle_pct   = 16;
  int rx_idle_pct   = 52;
  int hold_requests = 0;
  int cycle_count   = 0;
  int config_writes = 0;
  logic [ADDR_W-1:0]  cur_ks = KERNEL_SIZE_RESET;
  logic [SHIFT_W-1:0] cur_sh = ALIGN_SHIFT_RESET;

  always #10 clk = ~clk;

  memory_map_region_scanner DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full),
    .mem_type(mem_type), .region_base(region_base), .region_pages(region_pages),
    .last_entry(last_entry),
    .empty(empty), .pop(pop),
    .largest_found(largest_found), .largest_start(largest_start),
    .largest_bytes(largest_bytes), .usable_total(usable_total),
    .kernel_found(kernel_found), .kernel_base(kernel_base)
  );

  region_scan_checker region_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .push(push), .full(full),
    .mem_type(mem_type), .region_base(region_base), .region_pages(region_pages),
    .last_entry(last_entry),
    .empty(empty), .pop(pop),
    .largest_found(largest_found), .largest_start(largest_start),
    .largest_bytes(largest_bytes), .usable_total(usable_total),
    .kernel_found(kernel_found), .kernel_base(kernel_base),
    .fail_count(fail_count), .pending(pending),
    .descriptors_seen(descriptors_seen), .results_checked(results_checked)
  );

  function automatic logic [7:0] usable_kind();
    if ($urandom_range(4) == 4)
      return TYPE_CONVENTIONAL;
    return TYPE_LOADER_CODE + 8'($urandom_range(3));
  endfunction

  // Some regions sized and placed around the configured request, the rest random noise.
  function automatic region_t random_region(input logic [ADDR_W-1:0] ks,
                                            input logic [SHIFT_W-1:0] sh);
    region_t     r;
    logic [63:0] kpages;
    logic [63:0] wide;
    int          roll;
    roll = $urandom_range(99);
    if (roll < 55)
      r.kind = TYPE_CONVENTIONAL;
    else if (roll < 75)
      r.kind = usable_kind();
    else
      r.kind = 8'($urandom_range(255));

    roll = $urandom_range(99);
    wide = {$urandom, $urandom};
    if (roll < 30) begin
      r.base = wide[ADDR_W-1:0];
    end else if (roll < 60) begin
      r.base = {18'd0, wide[33:0]};
    end else begin
      wide = 64'($urandom_range(1, 64)) << sh;
      if (sh <= 20)
        wide += 64'h10_0000 * 64'($urandom_range(1, 16));
      if ($urandom_range(3) == 0)
        wide += 64'($urandom_range(4095));
      r.base = wide[ADDR_W-1:0];
    end

    kpages = ({12'd0, ks} + 64'd4095) >> 12;
    roll = $urandom_range(99);
    if (roll < 10)
      wide = 64'd0;
    else if (roll < 30)
      wide = {$urandom, $urandom};
    else if (roll < 65)
      wide = kpages + 64'($urandom_range(4)) - 64'd1;
    else
      wide = 64'($urandom_range(65536));
    r.pages = wide[PAGES_W-1:0];
    return r;
  endfunction

  task automatic send_region(input logic [7:0] kind, input logic [ADDR_W-1:0] base,
                             input logic [PAGES_W-1:0] pages, input logic closes_map);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    mem_type     <= kind;
    region_base  <= base;
    region_pages <= pages;
    last_entry   <= closes_map;
    do @(posedge clk); while (full);
  endtask

  // Stop offering requests and wait until every summary has been popped.
  task automatic drain_results();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [ADDR_W-1:0] ks, input logic [SHIFT_W-1:0] sh);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_KERNEL_SIZE, 3'b000};
    pwdata  <= {12'($urandom), ks};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    paddr   <= {REG_ALIGN_SHIFT, 3'b000};
    pwdata  <= {$urandom, 26'($urandom), sh};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_ks = ks;
    cur_sh = sh;
    config_writes += 2;
  endtask

  initial begin : result_side
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    region_t     r;
    logic [63:0] wide;
    int          map_len;
    int          sent;
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    push         <= 1'b0;
    mem_type     <= '0;
    region_base  <= '0;
    region_pages <= '0;
    last_entry   <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset config: 16 MiB request, 4 KiB alignment
    send_region(TYPE_CONVENTIONAL, 52'h0, 40'h100, 1'b0);             // below 1 MiB
    send_region(TYPE_CONVENTIONAL, 52'h10_0000, 40'h0, 1'b0);         // empty region
    send_region(TYPE_CONVENTIONAL, 52'h10_0001, 40'h1001, 1'b0);      // fits after rounding up
    send_region(TYPE_CONVENTIONAL, 52'h20_0000, 40'h1001, 1'b0);      // tie, later fit ignored
    send_region(TYPE_LOADER_CODE, ADDR_MAX, PAGES_MAX, 1'b0);
    send_region(TYPE_LOADER_DATA, 52'h0, 40'h1, 1'b0);
    send_region(TYPE_BOOT_CODE, 52'h1_2345, 40'h10, 1'b0);
    send_region(TYPE_BOOT_DATA, 52'h5, 40'h2, 1'b0);
    send_region(TYPE_RESERVED, ADDR_MAX, PAGES_MAX, 1'b0);
    send_region(TYPE_RUNTIME_CODE, ADDR_MAX, PAGES_MAX, 1'b0);
    send_region(TYPE_PERSISTENT, ADDR_MAX, PAGES_MAX, 1'b0);
    send_region(TYPE_FIRST_UNKNOWN, ADDR_MAX, PAGES_MAX, 1'b0);
    send_region(TYPE_TOP_CODE, ADDR_MAX, PAGES_MAX, 1'b0);
    send_region(TYPE_CONVENTIONAL, ADDR_MAX, PAGES_MAX, 1'b1);        // new largest
    send_region(TYPE_TOP_CODE, 52'h0, 40'h0, 1'b1);                   // map with nothing usable
    send_region(TYPE_CONVENTIONAL, 52'hF_FFFF_FFFF_F001, 40'h1_0000, 1'b0); // base rounds to 2^52
    send_region(TYPE_CONVENTIONAL, 52'h10_0000, 40'hFFF, 1'b0);       // one page short
    send_region(TYPE_CONVENTIONAL, 52'hF_FFFF, 40'h2000, 1'b1);       // starts under 1 MiB
    send_region(TYPE_CONVENTIONAL, 52'h10_0000, 40'h1000, 1'b1);      // exact fit
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_config(52'd0, 6'd12);
        1: write_config(52'd1, 6'd0);
        2: write_config(52'hF_FFFF_FFFF_F000, 6'd0);
        3: write_config(52'd12288, 6'd63);
        4: write_config(52'd8192, 6'd53);
        5: write_config(KERNEL_SIZE_RESET, ALIGN_SHIFT_RESET);
        6: write_config(52'd4096, 6'd52);
        7: write_config(ADDR_MAX, 6'd20);
        default: write_config(52'($urandom_range(1, 1 << 22)), 6'($urandom_range(24)));
      endcase
      if (ph < 4) begin
        tx_idle_pct = 16;
        rx_idle_pct = 52;
      end else if (ph < 8) begin
        tx_idle_pct = 52;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      // result side stalls while one-descriptor maps keep coming
      if (ph == PRESSURE_PHASE) begin
        hold_requests++;
        repeat (PRESSURE_MAPS) begin
          r = random_region(cur_ks, cur_sh);
          send_region(r.kind, r.base, r.pages, 1'b1);
        end
      end

      // long map of near-maximal usable regions pushes the total far past 52 bits
      if (ph == BIG_MAP_PHASE) begin
        for (int i = 0; i < BIG_MAP_LEN; i++) begin
          wide = {$urandom, $urandom};
          send_region(usable_kind(), wide[ADDR_W-1:0], PAGES_MAX - 40'($urandom_range(15)),
                      i == BIG_MAP_LEN - 1);
        end
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        map_len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
        for (int i = 0; i < map_len; i++) begin
          r = random_region(cur_ks, cur_sh);
          send_region(r.kind, r.base, r.pages, i == map_len - 1);
        end
        sent += map_len;
        if ($urandom_range(19) == 0)
          drain_results();
      end
      drain_results();
    end

    $display("Scanned %0d descriptors over %0d register writes and %0d settings,",
             descriptors_seen, config_writes, NUM_PHASES + 1);
    $display("with %0d map summaries compared and %0d mismatches.",
             results_checked, fail_count);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
hdl/mmrs_pkg.sv
hdl/mmrs_front.sv
hdl/mmrs_queue.sv
hdl/mmrs_back.sv
hdl/memory_map_region_scanner.sv
tb/region_scan_checker.sv
tb/memory_map_region_scanner_test.sv
